// File: rtl/pcmix_pkg.sv
// ----------------------------------------------------------------------------
// pcmix_pkg
// Shared types and constants for the PCM FIFO and cue voice mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmix_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_FIFO_DEPTH = 32768;
  localparam int DEF_TONE_DEPTH = 8192;
  localparam int DEF_CUE_KINDS  = 8;
  localparam int DEF_VOICES     = 4;

  // Item field widths
  localparam int ACT_W    = 3;
  localparam int SAMPLE_W = 16;
  localparam int BLEN_W   = 13;
  localparam int KIND_W   = 3;
  localparam int TIDX_W   = 13;
  localparam int TLEN_W   = 14;

  // Stream widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  // Saturation bounds
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  // Item opcodes carried on tuser
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_FRAME  = 3'd1,
    ACT_CUE    = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_TONE   = 3'd4,
    ACT_LENGTH = 3'd5
  } action_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_VOICE,
    ST_POP_R,
    ST_POP_W,
    ST_MIX
  } mix_state_e;

  // Latched input item
  typedef struct packed {
    action_e                    action;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       batch_start;
    logic [BLEN_W-1:0]          batch_length;
    logic [KIND_W-1:0]          cue_kind;
    logic                       audible;
    logic [TIDX_W-1:0]          tone_index;
    logic [TLEN_W-1:0]          tone_length;
  } in_item_t;

  // Commands to the sample FIFO
  typedef struct packed {
    logic                       push;
    logic                       pop;
    logic                       clear;
    logic                       batch_start;
    logic [BLEN_W-1:0]          batch_length;
    logic signed [SAMPLE_W-1:0] sample;
  } fifo_cmd_t;

  // Commands to the voice engine
  typedef struct packed {
    logic                       frame_start;
    logic                       cue;
    logic                       audible;
    logic                       tone_we;
    logic                       len_we;
    logic [KIND_W-1:0]          kind;
    logic [TIDX_W-1:0]          tone_index;
    logic [TLEN_W-1:0]          tone_length;
    logic signed [SAMPLE_W-1:0] sample;
  } voice_cmd_t;

endpackage

`default_nettype wire

// File: rtl/pcmix_fifo.sv
// ----------------------------------------------------------------------------
// pcmix_fifo
// Ring FIFO of PCM samples in a single-port style RAM with registered read.
// Handles push with batch room check, pop (zero when empty) and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmix_fifo import pcmix_pkg::*; #(
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fifo_cmd_t                  cmd_i,
  output logic signed [SAMPLE_W-1:0]      pop_data_o
);

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  logic [SAMPLE_W-1:0] mem [FIFO_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic                nz_q;

  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [PTR_W-1:0]  base_ptr;
  logic [FILL_W-1:0] base_fill;
  logic [PTR_W:0]    wr_sum;
  logic [PTR_W-1:0]  wr_addr;
  logic              wr_en;
  logic              rd_en;

  // Pointer and fill update
  always_comb begin
    base_ptr  = rd_ptr_q;
    base_fill = fill_q;
    // batch start that does not fit empties the FIFO first
    if (cmd_i.batch_start &&
        (32'(cmd_i.batch_length) > (32'(FIFO_DEPTH) - 32'(fill_q)))) begin
      base_ptr  = '0;
      base_fill = '0;
    end
    wr_sum  = (PTR_W+1)'(base_ptr) + (PTR_W+1)'(base_fill);
    wr_addr = (wr_sum >= (PTR_W+1)'(FIFO_DEPTH)) ?
              PTR_W'(wr_sum - (PTR_W+1)'(FIFO_DEPTH)) : PTR_W'(wr_sum);

    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    priority if (cmd_i.clear) begin
      rd_ptr_d = '0;
      fill_d   = '0;
    end else if (cmd_i.push) begin
      rd_ptr_d = base_ptr;
      fill_d   = base_fill;
      if (base_fill < FILL_W'(FIFO_DEPTH)) begin
        wr_en  = 1'b1;
        fill_d = base_fill + FILL_W'(1);
      end
    end else if (cmd_i.pop) begin
      if (fill_q != '0) begin
        rd_en    = 1'b1;
        rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
        fill_d   = fill_q - FILL_W'(1);
      end
    end
  end

  // Sample RAM
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.sample;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      fill_q   <= '0;
      nz_q     <= 1'b0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      nz_q     <= rd_en;
    end
  end

  // Empty pop reads as zero
  assign pop_data_o = nz_q ? signed'(rdata_q) : '0;

endmodule

`default_nettype wire

// File: rtl/pcmix_voice.sv
// ----------------------------------------------------------------------------
// pcmix_voice
// Cue voice engine: tone RAM, per-kind lengths and voice state. A frame
// walks the voices one per cycle, reads each active voice's tone sample and
// accumulates the sum in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmix_voice import pcmix_pkg::*; #(
  parameter int TONE_DEPTH = DEF_TONE_DEPTH,
  parameter int CUE_KINDS  = DEF_CUE_KINDS,
  parameter int VOICES     = DEF_VOICES
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire voice_cmd_t                                 cmd_i,
  output logic                                            done_o,
  output logic signed [SAMPLE_W+$clog2(VOICES)-1:0]       tone_sum_o
);

  localparam int POS_W  = $clog2(TONE_DEPTH + 1);
  localparam int IDX_W  = $clog2(TONE_DEPTH);
  localparam int ADDR_W = $clog2(CUE_KINDS * TONE_DEPTH);
  localparam int KSEL_W = $clog2(CUE_KINDS);
  localparam int VSEL_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(VOICES);

  logic [SAMPLE_W-1:0] tmem [CUE_KINDS * TONE_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;

  logic [KIND_W-1:0] kind_q [VOICES];
  logic [POS_W-1:0]  pos_q  [VOICES];
  logic [TLEN_W-1:0] len_q  [CUE_KINDS];
  logic [VSEL_W-1:0] slot_q;
  logic [VSEL_W-1:0] vidx_q;
  logic              busy_q, drain_q, done_q, rd_vld_q;
  logic signed [SUM_W-1:0] acc_q;

  logic [KIND_W-1:0] cur_kind;
  logic [POS_W-1:0]  cur_pos;
  logic [IDX_W-1:0]  cur_p;
  logic [POS_W-1:0]  cur_next;
  logic [TLEN_W-1:0] cur_len;
  logic              cur_active;
  logic              cur_stop;
  logic              cur_last;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_ok;
  logic              cue_ok;
  logic              len_ok;
  logic [TLEN_W-1:0] len_val;

  // Current voice of the frame walk
  always_comb begin
    cur_kind   = kind_q[vidx_q];
    cur_pos    = pos_q[vidx_q];
    cur_active = busy_q && (cur_kind != '0);
    cur_p      = (cur_pos == POS_W'(TONE_DEPTH)) ? '0 : IDX_W'(cur_pos);
    cur_next   = POS_W'(cur_p) + POS_W'(1);
    cur_len    = len_q[KSEL_W'(cur_kind)];
    cur_stop   = 32'(cur_next) >= 32'(cur_len);
    cur_last   = (vidx_q == VSEL_W'(VOICES - 1));
    rd_addr    = ADDR_W'(cur_kind) * ADDR_W'(TONE_DEPTH) + ADDR_W'(cur_p);
  end

  // Decode of table writes and cue starts
  always_comb begin
    wr_ok   = (32'(cmd_i.kind) < 32'(CUE_KINDS)) &&
              (32'(cmd_i.tone_index) < 32'(TONE_DEPTH));
    wr_addr = ADDR_W'(cmd_i.kind) * ADDR_W'(TONE_DEPTH) + ADDR_W'(cmd_i.tone_index);
    cue_ok  = (cmd_i.kind != '0) && (32'(cmd_i.kind) < 32'(CUE_KINDS));
    len_ok  = 32'(cmd_i.kind) < 32'(CUE_KINDS);
    len_val = (32'(cmd_i.tone_length) > 32'(TONE_DEPTH)) ?
              TLEN_W'(TONE_DEPTH) : cmd_i.tone_length;
  end

  // Tone RAM
  always_ff @(posedge clk_i) begin
    if (cmd_i.tone_we && wr_ok) begin
      tmem[wr_addr] <= cmd_i.sample;
    end
    if (cur_active) begin
      rdata_q <= signed'(tmem[rd_addr]);
    end
  end

  // Voice state, lengths and frame sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        kind_q[v] <= '0;
        pos_q[v]  <= '0;
      end
      for (int k = 0; k < CUE_KINDS; k++) begin
        len_q[k] <= '0;
      end
      slot_q   <= '0;
      vidx_q   <= '0;
      busy_q   <= 1'b0;
      drain_q  <= 1'b0;
      done_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      rd_vld_q <= cur_active;
      drain_q  <= busy_q && cur_last;
      done_q   <= drain_q;

      // accumulate last cycle's tone read
      if (cmd_i.frame_start) begin
        acc_q <= '0;
      end else if (rd_vld_q) begin
        acc_q <= acc_q + SUM_W'(rdata_q);
      end

      if (cmd_i.frame_start) begin
        busy_q <= 1'b1;
        vidx_q <= '0;
      end else if (busy_q) begin
        if (cur_active) begin
          pos_q[vidx_q] <= cur_next;
          if (cur_stop) begin
            kind_q[vidx_q] <= '0;
          end
        end
        if (cur_last) begin
          busy_q <= 1'b0;
        end else begin
          vidx_q <= vidx_q + VSEL_W'(1);
        end
      end

      // cue start on the next round-robin voice, or silence all
      if (cmd_i.cue) begin
        if (!cmd_i.audible) begin
          for (int v = 0; v < VOICES; v++) begin
            kind_q[v] <= '0;
          end
        end else if (cue_ok) begin
          kind_q[slot_q] <= cmd_i.kind;
          pos_q[slot_q]  <= '0;
          slot_q <= (slot_q == VSEL_W'(VOICES - 1)) ? '0 : slot_q + VSEL_W'(1);
        end
      end

      if (cmd_i.len_we && len_ok) begin
        len_q[KSEL_W'(cmd_i.kind)] <= len_val;
      end
    end
  end

  assign done_o     = done_q;
  assign tone_sum_o = acc_q;

endmodule

`default_nettype wire

// File: rtl/pcm_fifo_cue_voice_mixer.sv
// Sequence: an output frame passes through the EXEC, VOICE, POP_R, POP_W and MIX
//   states before its result; every other item executes in EXEC and gives no result.
// Flow: one item at a time; a frame holds the input from its accept to the next
//   accept, set by the voice walk (one tone RAM read per active voice) and the two
//   FIFO RAM pops, plus any output stall.
// Reset: asynchronous, active low; clears FIFO pointers, cue lengths and voices.
//   Sample and tone RAM contents are not cleared.
// ----------------------------------------------------------------------------
// pcm_fifo_cue_voice_mixer
// Stereo PCM sample FIFO mixed with round-robin cue voices from a tone RAM,
// saturated to 16 bits per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_fifo_cue_voice_mixer import pcmix_pkg::*; #(
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH,
  parameter int TONE_DEPTH = DEF_TONE_DEPTH,
  parameter int CUE_KINDS  = DEF_CUE_KINDS,
  parameter int VOICES     = DEF_VOICES
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: sample[15:0], batch_start[16], batch_length[29:17], cue_kind[32:30],
  //        audible[33], tone_index[46:34], tone_length[60:47], zero[63:61]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: action[2:0]
  input  wire logic [ACT_W-1:0]       s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata: left[15:0], right[31:16]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int SUM_W = SAMPLE_W + $clog2(VOICES);
  localparam int MIX_W = SUM_W + 1;

  mix_state_e state_q, state_d;
  in_item_t   item_q;
  fifo_cmd_t  fifo_cmd;
  voice_cmd_t voice_cmd;

  logic signed [SAMPLE_W-1:0] pop_data;
  logic signed [SUM_W-1:0]    tone_sum;
  logic                       v_done;

  logic signed [SAMPLE_W-1:0] left_q, right_q;
  logic                       out_vld_q;
  logic [OUT_TDATA_W-1:0]     out_data_q;
  logic                       out_free;
  logic                       out_load;
  logic                       take_item;
  logic signed [MIX_W-1:0]    mix_l, mix_r;

  function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [MIX_W-1:0] v);
    logic signed [MIX_W-1:0] hi;
    logic signed [MIX_W-1:0] lo;
    hi = MIX_W'(SAT_MAX);
    lo = MIX_W'(SAT_MIN);
    if (v > hi) begin
      return SAMPLE_W'(SAT_MAX);
    end else if (v < lo) begin
      return SAMPLE_W'(SAT_MIN);
    end
    return SAMPLE_W'(v);
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign take_item     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  // Input item register
  always_ff @(posedge clk_i) begin
    if (take_item) begin
      item_q.action       <= action_e'(s_axis_tuser);
      item_q.sample       <= signed'(s_axis_tdata[15:0]);
      item_q.batch_start  <= s_axis_tdata[16];
      item_q.batch_length <= s_axis_tdata[29:17];
      item_q.cue_kind     <= s_axis_tdata[32:30];
      item_q.audible      <= s_axis_tdata[33];
      item_q.tone_index   <= s_axis_tdata[46:34];
      item_q.tone_length  <= s_axis_tdata[60:47];
    end
  end

  // Sequencer: next state and commands
  always_comb begin
    state_d   = state_q;
    out_load  = 1'b0;

    fifo_cmd              = '0;
    fifo_cmd.batch_start  = item_q.batch_start;
    fifo_cmd.batch_length = item_q.batch_length;
    fifo_cmd.sample       = item_q.sample;

    voice_cmd             = '0;
    voice_cmd.audible     = item_q.audible;
    voice_cmd.kind        = item_q.cue_kind;
    voice_cmd.tone_index  = item_q.tone_index;
    voice_cmd.tone_length = item_q.tone_length;
    voice_cmd.sample      = item_q.sample;

    unique case (state_q)
      ST_IDLE: begin
        if (take_item) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        unique case (item_q.action)
          ACT_PUSH:   fifo_cmd.push = 1'b1;
          ACT_FRAME: begin
            voice_cmd.frame_start = 1'b1;
            state_d = ST_VOICE;
          end
          ACT_CUE:    voice_cmd.cue     = 1'b1;
          ACT_CLEAR:  fifo_cmd.clear    = 1'b1;
          ACT_TONE:   voice_cmd.tone_we = 1'b1;
          ACT_LENGTH: voice_cmd.len_we  = 1'b1;
          default:    ;
        endcase
      end
      ST_VOICE: begin
        // tone sum ready: pop left
        if (v_done) begin
          fifo_cmd.pop = 1'b1;
          state_d      = ST_POP_R;
        end
      end
      ST_POP_R: begin
        fifo_cmd.pop = 1'b1;
        state_d      = ST_POP_W;
      end
      ST_POP_W: begin
        state_d = ST_MIX;
      end
      ST_MIX: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture popped PCM samples
  always_ff @(posedge clk_i) begin
    if (state_q == ST_POP_R) begin
      left_q <= pop_data;
    end
    if (state_q == ST_POP_W) begin
      right_q <= pop_data;
    end
  end

  // Mix and saturate
  assign mix_l = MIX_W'(left_q) + MIX_W'(tone_sum);
  assign mix_r = MIX_W'(right_q) + MIX_W'(tone_sum);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {sat16(mix_r), sat16(mix_l)};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  pcmix_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (fifo_cmd),
    .pop_data_o (pop_data)
  );

  pcmix_voice #(
    .TONE_DEPTH (TONE_DEPTH),
    .CUE_KINDS  (CUE_KINDS),
    .VOICES     (VOICES)
  ) u_voice (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (voice_cmd),
    .done_o     (v_done),
    .tone_sum_o (tone_sum)
  );

`ifndef NO_ASSERTIONS
  // voice walk finishes only while the sequencer waits for it
  a_done_in_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_done |-> (state_q == ST_VOICE))
    else $error("voice done outside voice wait");

  // frame start is followed by voice done once the walk and its drain and done registers are through
  a_frame_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    voice_cmd.frame_start |-> ##(VOICES + 2) v_done)
    else $error("voice walk timing off");

  // a new result appears only after the mix step
  a_result_after_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_MIX))
    else $error("result without a frame");

  // no pop while items are being accepted
  a_no_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !fifo_cmd.pop)
    else $error("fifo pop in idle");
`endif

endmodule

`default_nettype wire
